// ----- sv/lozf_pkg.sv -----
// ----------------------------------------------------------------------------
// lozf_pkg
// Shared types, constants and the cosine table generator for the lidar
// obstacle zone filter.
// ----------------------------------------------------------------------------
package lozf_pkg;

   // cosine table resolution per full turn (log2 of entries)
   localparam int unsigned COS_TABLE_BITS_DEF = 10;

   // widths fixed by the field formats
   localparam int unsigned ANGLE_W  = 16;
   localparam int unsigned DIST_W   = 18;
   localparam int unsigned ZONE_W   = 2;
   localparam int unsigned COS_W    = 15;   // Q0.15 magnitude
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // running minimum at scan start: 65000 mm in quarter millimetres
   localparam logic [DIST_W-1:0] SCAN_START_MIN = 18'd260000;

   // angle landmarks, 17 bits wide so that angle + half window fits
   localparam logic [ANGLE_W:0] FULL_TURN = 17'd65536;
   localparam logic [ANGLE_W:0] HALF_TURN = 17'd32768;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_THR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_THR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_THR  = 3'd4;

   // register reset values
   localparam logic signed [1:0]      DIRECTION_RST = 2'sd0;
   localparam logic [CSR_DATA_W-1:0]  HALF_WIN_RST  = 16'd5461;
   localparam logic [CSR_DATA_W-1:0]  FAR_THR_RST   = 16'd1000;
   localparam logic [CSR_DATA_W-1:0]  MID_THR_RST   = 16'd600;
   localparam logic [CSR_DATA_W-1:0]  NEAR_THR_RST  = 16'd300;

   // zone codes
   localparam logic [ZONE_W-1:0] ZONE_NONE   = 2'd0;
   localparam logic [ZONE_W-1:0] ZONE_EXISTS = 2'd1;
   localparam logic [ZONE_W-1:0] ZONE_CLOSE  = 2'd2;
   localparam logic [ZONE_W-1:0] ZONE_DANGER = 2'd3;

   // request beat
   typedef struct packed {
      logic [ANGLE_W-1:0] angle_q14;
      logic [DIST_W-1:0]  dist_q2;
      logic               first_of_scan;
      logic               last_of_scan;
   } lozf_req_type;

   // response beat
   typedef struct packed {
      logic [ZONE_W-1:0]  zone;
      logic [DIST_W-1:0]  nearest_dist_q2;
      logic [ANGLE_W-1:0] nearest_angle_q14;
   } lozf_rsp_type;

   // registered point plus its looked-up cosine
   typedef struct packed {
      lozf_req_type       req;
      logic               cos_neg;
      logic [COS_W-1:0]   cos_mag;
   } lozf_stage_type;

   // first-quadrant cosine magnitude in Q15, elaboration time only.
   // r is the folded table index, bits the table resolution per turn.
   function automatic logic [COS_W-1:0] quad_cos(input int unsigned r,
                                                 input int unsigned bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        mag;
      x    = (64'(r) * 64'd6746518852) >> bits;
      x2   = (x * x) >> 30;
      term = 64'd1073741824;
      sum  = 64'sd1073741824;
      // Taylor terms up to x^12, alternating sign
      term = ((term * x2) >> 30) / 64'd2;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd12;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd30;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd56;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd90;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd132;
      sum  = sum + $signed(term);
      // round half away from zero to Q15, saturate; sign is dropped here
      if (sum < 0) begin
         mag = ($unsigned(-sum) + 64'd16384) >> 15;
      end else begin
         mag = ($unsigned(sum) + 64'd16384) >> 15;
      end
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      return mag[COS_W-1:0];
   endfunction

endpackage

// ----- sv/lidar_obstacle_zone_filter_core.sv -----
// ----------------------------------------------------------------------------
// lidar_obstacle_zone_filter_core
// Per-scan obstacle zone filter for a rotating range sensor.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one point per beat: angle (65536 units per turn), distance
//          in quarter mm (zero is invalid), and first/last scan marks.
//   rsp_*  carries one beat per last_of_scan point: zone, scan minimum and the
//          angle of the latest accepted point.
//   csr_*  writes direction, half window and the three thresholds; write only
//          while no points are in flight.
// Timing: a point is registered together with its cosine ROM read; from that
//   register the projection multiply, compare and state update run, and the
//   response register loads when a scan-end point moves on. One point per
//   cycle is taken while no scan-end point waits on a stalled response,
//   limited by the min/multiply/compare feedback loop on the running minimum.
// Stall: a stalled response holds its beat; points that do not end a scan keep
//   flowing, and a scan-end point waits in the input register, which then
//   raises req_stall.
// Reset: registers return to their defaults, the running minimum to 65000 mm
//   and the held angle to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lidar_obstacle_zone_filter_core #(
   parameter int unsigned COS_TABLE_BITS = lozf_pkg::COS_TABLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lozf_pkg::lozf_req_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lozf_pkg::lozf_rsp_type           rsp_data,
   input  logic                             csr_wr_en,
   input  logic [lozf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lozf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lozf_pkg::*;

   logic           stage_valid;
   lozf_stage_type stage;
   logic           advance;

   // input register and cosine lookup
   lozf_in_stage #(
      .COS_TABLE_BITS(COS_TABLE_BITS)
   ) u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .stage_valid(stage_valid),
      .stage      (stage)
   );

   // scan state and response
   lozf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .stage_valid(stage_valid),
      .stage      (stage),
      .advance    (advance),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- sv/lozf_in_stage.sv -----
// ----------------------------------------------------------------------------
// lozf_in_stage
// Input register for one point, with the cosine read from a quarter-wave
// ROM registered alongside it.
// ----------------------------------------------------------------------------
module lozf_in_stage #(
   parameter int unsigned COS_TABLE_BITS = lozf_pkg::COS_TABLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lozf_pkg::lozf_req_type   req_data,
   input  logic                     advance,
   output logic                     stage_valid,
   output lozf_pkg::lozf_stage_type stage
);
   import lozf_pkg::*;

   localparam int unsigned QN     = 1 << (COS_TABLE_BITS - 2);
   localparam int unsigned ADDR_W = COS_TABLE_BITS - 1;

   typedef logic [COS_W-1:0] quad_tab_type [QN+1];

   function automatic quad_tab_type build_quad_tab();
      quad_tab_type t;
      for (int unsigned i = 0; i <= QN; i++) begin
         t[i] = quad_cos(i, COS_TABLE_BITS);
      end
      return t;
   endfunction

   localparam quad_tab_type QUAD_TAB = build_quad_tab();

   logic [COS_TABLE_BITS-1:0] tab_idx;
   logic [1:0]                quadrant;
   logic [ADDR_W-2:0]         idx_low;
   logic [ADDR_W-1:0]         rom_addr;
   logic                      accept;

   logic                      valid_ff;
   logic                      valid_in;
   lozf_stage_type            stage_ff;

   // table index from the top angle bits, folded into the first quadrant
   assign tab_idx  = req_data.angle_q14[ANGLE_W-1 -: COS_TABLE_BITS];
   assign quadrant = tab_idx[COS_TABLE_BITS-1 -: 2];
   assign idx_low  = tab_idx[COS_TABLE_BITS-3:0];
   assign rom_addr = quadrant[0] ? (ADDR_W'(QN) - {1'b0, idx_low}) : {1'b0, idx_low};

   // hold the point while the core cannot take it
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload and registered ROM read
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff.req     <= req_data;
         stage_ff.cos_neg <= quadrant[1] ^ quadrant[0];
         stage_ff.cos_mag <= QUAD_TAB[rom_addr];
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

// ----- sv/lozf_core.sv -----
// ----------------------------------------------------------------------------
// lozf_core
// Scan state, acceptance test, zone classification, configuration
// registers and the response register.
// ----------------------------------------------------------------------------
module lozf_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 stage_valid,
   input  lozf_pkg::lozf_stage_type             stage,
   output logic                                 advance,
   input  logic                                 csr_wr_en,
   input  logic [lozf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lozf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lozf_pkg::lozf_rsp_type               rsp_data
);
   import lozf_pkg::*;

   // configuration registers
   logic signed [1:0]     direction_ff;
   logic [CSR_DATA_W-1:0] half_win_ff;
   logic [CSR_DATA_W-1:0] far_thr_ff;
   logic [CSR_DATA_W-1:0] mid_thr_ff;
   logic [CSR_DATA_W-1:0] near_thr_ff;

   // scan state
   logic [DIST_W-1:0]  running_min_ff;
   logic [DIST_W-1:0]  running_min_in;
   logic [ANGLE_W-1:0] held_angle_ff;
   logic [ANGLE_W-1:0] held_angle_in;

   // response register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   lozf_rsp_type       rsp_data_ff;
   lozf_rsp_type       rsp_data_in;

   logic                   out_free;
   logic [ANGLE_W:0]       ang_ext;
   logic [ANGLE_W:0]       ang_sum;
   logic                   in_front;
   logic                   in_rear;
   logic [DIST_W+COS_W-1:0] proj;
   logic [DIST_W+COS_W-1:0] lhs;
   logic                   proj_pos;
   logic                   hit;
   logic [DIST_W-1:0]      min_next;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIRECTION_RST;
         half_win_ff  <= HALF_WIN_RST;
         far_thr_ff   <= FAR_THR_RST;
         mid_thr_ff   <= MID_THR_RST;
         near_thr_ff  <= NEAR_THR_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DIRECTION: direction_ff <= csr_wdata[1:0];
            CSR_HALF_WIN:  half_win_ff  <= csr_wdata;
            CSR_FAR_THR:   far_thr_ff   <= csr_wdata;
            CSR_MID_THR:   mid_thr_ff   <= csr_wdata;
            CSR_NEAR_THR:  near_thr_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // a point moves on unless it ends a scan and the response slot is busy
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = stage_valid && (!stage.req.last_of_scan || out_free);

   // front and rear angle windows
   assign ang_ext  = {1'b0, stage.req.angle_q14};
   assign ang_sum  = ang_ext + {1'b0, half_win_ff};
   assign in_front = (ang_ext < {1'b0, half_win_ff}) || (ang_sum > FULL_TURN);
   assign in_rear  = (ang_sum > HALF_TURN) && (ang_ext < (HALF_TURN + {1'b0, half_win_ff}));

   // projected minimum against the scaled distance
   assign proj = running_min_ff * stage.cos_mag;
   assign lhs  = {stage.req.dist_q2, {COS_W{1'b0}}};
   // sign of the projection: cosine sign, flipped when backward, ignored for both
   assign proj_pos = (direction_ff == 2'sd0) || !(stage.cos_neg ^ direction_ff[1]);
   assign hit = (stage.req.dist_q2 != '0) && (in_front || in_rear) && proj_pos && (lhs < proj);

   // state update
   always_comb begin
      min_next      = running_min_ff;
      held_angle_in = held_angle_ff;
      if (stage.req.first_of_scan) begin
         min_next = SCAN_START_MIN;
      end else if (hit) begin
         min_next      = stage.req.dist_q2;
         held_angle_in = stage.req.angle_q14;
      end
      running_min_in = stage.req.last_of_scan ? SCAN_START_MIN : min_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_min_ff <= SCAN_START_MIN;
         held_angle_ff  <= '0;
      end else if (advance) begin
         running_min_ff <= running_min_in;
         held_angle_ff  <= held_angle_in;
      end
   end

   // zone classification on the scan minimum
   always_comb begin
      rsp_data_in.nearest_dist_q2   = min_next;
      rsp_data_in.nearest_angle_q14 = held_angle_in;
      if (min_next >= {far_thr_ff, 2'b00}) begin
         rsp_data_in.zone = ZONE_NONE;
      end else if (min_next >= {mid_thr_ff, 2'b00}) begin
         rsp_data_in.zone = ZONE_EXISTS;
      end else if (min_next >= {near_thr_ff, 2'b00}) begin
         rsp_data_in.zone = ZONE_CLOSE;
      end else begin
         rsp_data_in.zone = ZONE_DANGER;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && stage.req.last_of_scan) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage.req.last_of_scan) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a new response beat only follows a scan end that moved on
   a_rsp_from_scan_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(advance && stage.req.last_of_scan))
      else $error("response beat without a scan end");

   // the minimum restarts after every scan end
   a_min_restart: assert property (@(posedge clock) disable iff (reset)
      advance && stage.req.last_of_scan |=> running_min_ff == SCAN_START_MIN)
      else $error("running minimum not restarted after scan end");

   // the minimum never rises above its start value
   a_min_bound: assert property (@(posedge clock) disable iff (reset)
      running_min_ff <= SCAN_START_MIN)
      else $error("running minimum above start value");

   // a held point is blocked only by a stalled, full response slot
   a_block_cause: assert property (@(posedge clock) disable iff (reset)
      stage_valid && !advance |-> rsp_valid_ff && rsp_stall)
      else $error("point blocked without response back-pressure");
`endif

endmodule
